FILE: rtl/mtnt_pkg.sv
package mtnt_pkg;

    typedef logic signed [15:0] t_s16;
    typedef logic signed [31:0] t_s32;
    typedef logic signed [63:0] t_s64;

    typedef enum logic [1:0] {
        CFG_SCALE_X = 2'd0,
        CFG_SCALE_Y = 2'd1,
        CFG_SCALE_Z = 2'd2
    } t_cfg_idx;

    localparam t_s16 SCALE_RESET = 16'sd4096;
    localparam t_s16 SCALE_MIN   = -16'sd32768;
    localparam t_s16 SCALE_MAX   = 16'sd32767;
    localparam t_s16 UNIT_ONE    = 16'sd16384;

    // register stages inside the normalizer
    localparam int UNIT_LAT  = 18;
    // stages ahead of the normalizer
    localparam int FRONT_LAT = 4;
    localparam int PIPE_LAST = FRONT_LAT + UNIT_LAT - 1;

endpackage

FILE: rtl/mirrored_triangle_normal_tangent.sv
// channel  | dir | signals             | content
// s_axis   | in  | tdata[143:0]        | one triangle, nine coordinates
//          |     | tuser[2:0]          | mirror flags
// m_axis   | out | tdata[191:0], tlast | one vertex, tlast on the third
// i_cfg    | in  | wen, idx, wdata     | axis scale writes
// a triangle runs through 22 register stages: four for scaling, edges and
// cross product, eighteen in each normalizer (square root and divider)
// the output register sends three vertices and loads the next on the third
// a blocked output stalls the whole pipeline; nothing is dropped or repeated
// reset clears valid bits and sets all scales to SCALE_RESET (4096)
module mirrored_triangle_normal_tangent (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // first_x, first_y, first_z, second_x .. third_z
    input  logic [143:0] s_axis_tdata,
    // mirror_x, mirror_y, mirror_z
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // position_x/y/z, normal_x/y/z, tangent_x/y/z
    output logic [191:0] m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         i_cfg_wen,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_wdata
);
    import mtnt_pkg::*;

    t_s16 r_scale [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale[0] <= SCALE_RESET;
            r_scale[1] <= SCALE_RESET;
            r_scale[2] <= SCALE_RESET;
        end else if (i_cfg_wen) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SCALE_X: r_scale[0] <= i_cfg_wdata;
                CFG_SCALE_Y: r_scale[1] <= i_cfg_wdata;
                CFG_SCALE_Z: r_scale[2] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic r_v [PIPE_LAST+1];
    logic w_en;
    logic w_load;
    logic w_take;

    // stage 1: signed scales, winding swap, products
    t_s16 n_sc [3];
    t_s32 n_p  [3][3];
    logic w_odd;
    t_s32 r_p1 [3][3];

    assign w_odd = ^s_axis_tuser;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_sc[a] = r_scale[a];
            if (s_axis_tuser[a]) begin
                n_sc[a] = (r_scale[a] == SCALE_MIN) ? SCALE_MAX : -r_scale[a];
            end
        end
        for (int k = 0; k < 3; k++) begin
            for (int a = 0; a < 3; a++) begin
                if (w_odd && k == 1) begin
                    n_p[k][a] = n_sc[a] * $signed(s_axis_tdata[(2*3+a)*16 +: 16]);
                end else if (w_odd && k == 2) begin
                    n_p[k][a] = n_sc[a] * $signed(s_axis_tdata[(1*3+a)*16 +: 16]);
                end else begin
                    n_p[k][a] = n_sc[a] * $signed(s_axis_tdata[(k*3+a)*16 +: 16]);
                end
            end
        end
    end

    // stage 2: edges reduced below 2^30
    logic signed [32:0] n_e1 [3];
    logic signed [32:0] n_e2 [3];
    logic [31:0]        n_m1 [3];
    logic [31:0]        n_m2 [3];
    logic [31:0]        n_or;
    logic [1:0]         n_shift;
    logic [31:0]        n_s1, n_s2;
    logic signed [30:0] n_r1 [3];
    logic signed [30:0] n_r2 [3];
    t_s32               r_p2 [3][3];
    logic signed [32:0] r_e1_2 [3];
    logic signed [30:0] r_r1 [3];
    logic signed [30:0] r_r2 [3];

    always_comb begin
        n_or = '0;
        for (int a = 0; a < 3; a++) begin
            n_e1[a] = 33'(r_p1[1][a]) - 33'(r_p1[0][a]);
            n_e2[a] = 33'(r_p1[2][a]) - 33'(r_p1[0][a]);
            n_m1[a] = n_e1[a][32] ? 32'(-n_e1[a]) : n_e1[a][31:0];
            n_m2[a] = n_e2[a][32] ? 32'(-n_e2[a]) : n_e2[a][31:0];
            n_or    = n_or | n_m1[a] | n_m2[a];
        end
        n_shift = n_or[31] ? 2'd2 : (n_or[30] ? 2'd1 : 2'd0);
        for (int a = 0; a < 3; a++) begin
            n_s1    = n_m1[a] >> n_shift;
            n_s2    = n_m2[a] >> n_shift;
            n_r1[a] = n_e1[a][32] ? -$signed(n_s1[30:0]) : $signed(n_s1[30:0]);
            n_r2[a] = n_e2[a][32] ? -$signed(n_s2[30:0]) : $signed(n_s2[30:0]);
        end
    end

    // stage 3: cross product terms, stage 4: differences
    logic signed [61:0] r_pr [6];
    t_s32               r_p3 [3][3];
    logic signed [32:0] r_e1_3 [3];
    t_s32               r_p4 [3][3];
    t_s64               r_cr [3];
    t_s64               r_tg [3];
    t_s32               r_pd [UNIT_LAT][3][3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1 <= n_p;
            r_p2 <= r_p1;
            r_e1_2 <= n_e1;
            r_r1 <= n_r1;
            r_r2 <= n_r2;
            r_p3 <= r_p2;
            r_e1_3 <= r_e1_2;
            r_pr[0] <= r_r1[1] * r_r2[2];
            r_pr[1] <= r_r1[2] * r_r2[1];
            r_pr[2] <= r_r1[2] * r_r2[0];
            r_pr[3] <= r_r1[0] * r_r2[2];
            r_pr[4] <= r_r1[0] * r_r2[1];
            r_pr[5] <= r_r1[1] * r_r2[0];
            r_p4 <= r_p3;
            for (int a = 0; a < 3; a++) begin
                r_cr[a] <= 64'(r_pr[2*a]) - 64'(r_pr[2*a+1]);
                r_tg[a] <= 64'(r_e1_3[a]);
            end
            r_pd[0] <= r_p4;
            for (int k = 1; k < UNIT_LAT; k++) r_pd[k] <= r_pd[k-1];
        end
    end

    t_s16 w_nrm [3];
    t_s16 w_tan [3];
    logic w_nz_n, w_nz_t;

    mtnt_norm u_norm_n (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vec  (r_cr),
        .o_unit (w_nrm),
        .o_nz   (w_nz_n)
    );

    mtnt_norm u_norm_t (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vec  (r_tg),
        .o_unit (w_tan),
        .o_nz   (w_nz_t)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= PIPE_LAST; k++) r_v[k] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= s_axis_tvalid;
            for (int k = 1; k <= PIPE_LAST; k++) r_v[k] <= r_v[k-1];
        end
    end

    // output register, one vertex per transfer
    logic       r_ov;
    logic [1:0] r_idx;
    t_s32       r_op [3][3];
    t_s16       r_on [3];
    t_s16       r_ot [3];

    assign w_take = r_ov && m_axis_tready;
    assign w_load = r_v[PIPE_LAST] && (!r_ov || (w_take && r_idx == 2'd2));
    assign w_en   = !r_v[PIPE_LAST] || w_load;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_idx <= 2'd0;
        end else if (w_load) begin
            r_ov  <= 1'b1;
            r_idx <= 2'd0;
        end else if (w_take) begin
            if (r_idx == 2'd2) r_ov <= 1'b0;
            else r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_op <= r_pd[UNIT_LAT-1];
            if (w_nz_n && w_nz_t) begin
                r_on <= w_nrm;
                r_ot <= w_tan;
            end else begin
                // degenerate face
                r_on[0] <= '0;
                r_on[1] <= UNIT_ONE;
                r_on[2] <= '0;
                r_ot[0] <= UNIT_ONE;
                r_ot[1] <= '0;
                r_ot[2] <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tlast  = (r_idx == 2'd2);
    assign m_axis_tdata  = {r_ot[2], r_ot[1], r_ot[0], r_on[2], r_on[1], r_on[0],
                            r_op[r_idx][2], r_op[r_idx][1], r_op[r_idx][0]};

endmodule

FILE: rtl/mtnt_norm.sv
module mtnt_norm (
    input  logic           i_clk,
    input  logic           i_en,
    input  mtnt_pkg::t_s64 i_vec [3],
    output mtnt_pkg::t_s16 o_unit [3],
    output logic           o_nz
);
    import mtnt_pkg::*;

    typedef struct packed {
        logic [2:0][23:0] m;
        logic [2:0]       sgn;
        logic             nz;
    } t_tag;

    function automatic logic [5:0] lead_pos(input logic [62:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 63; i++) begin
            if (v[i]) p = 6'(i);
        end
        return p;
    endfunction

    // stage a: magnitudes
    logic [62:0] n_mag [3];
    logic [62:0] r_a_mag [3];
    logic [2:0]  r_a_sgn;
    logic [62:0] r_a_or;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = i_vec[i][63] ? 63'(-i_vec[i]) : i_vec[i][62:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_a_mag[i] <= n_mag[i];
                r_a_sgn[i] <= i_vec[i][63];
            end
            r_a_or <= n_mag[0] | n_mag[1] | n_mag[2];
        end
    end

    // stage b: leading one of the largest magnitude
    logic [62:0] r_b_mag [3];
    logic [2:0]  r_b_sgn;
    logic [5:0]  r_b_pos;
    logic        r_b_nz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_mag <= r_a_mag;
            r_b_sgn <= r_a_sgn;
            r_b_pos <= lead_pos(r_a_or);
            r_b_nz  <= |r_a_or;
        end
    end

    // stage c: bring the largest into [2^23, 2^24)
    t_tag n_tag;
    t_tag r_dl [15];

    always_comb begin
        n_tag.sgn = r_b_sgn;
        n_tag.nz  = r_b_nz;
        for (int i = 0; i < 3; i++) begin
            if (r_b_pos >= 6'd23) begin
                n_tag.m[i] = 24'(r_b_mag[i] >> (r_b_pos - 6'd23));
            end else begin
                n_tag.m[i] = 24'(r_b_mag[i] << (6'd23 - r_b_pos));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dl[0] <= n_tag;
            for (int k = 1; k < 15; k++) r_dl[k] <= r_dl[k-1];
        end
    end

    // stages d, e: sum of squares
    logic [47:0] r_sq [3];
    logic [49:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) r_sq[i] <= r_dl[0].m[i] * r_dl[0].m[i];
            r_sum <= 50'(r_sq[0]) + 50'(r_sq[1]) + 50'(r_sq[2]);
        end
    end

    // square root, four result bits per stage
    logic [55:0] r_qs [7];
    logic [55:0] r_qr [7];

    for (genvar g = 0; g < 7; g++) begin : g_sqrt
        logic [55:0] s_in, r_in, s, r, b;
        if (g == 0) begin : g_first
            assign s_in = 56'(r_sum);
            assign r_in = '0;
        end else begin : g_next
            assign s_in = r_qs[g-1];
            assign r_in = r_qr[g-1];
        end
        always_comb begin
            s = s_in;
            r = r_in;
            b = '0;
            for (int j = 0; j < 4; j++) begin
                b = 56'(1) << (54 - 2 * (4 * g + j));
                if (s >= r + b) begin
                    s = s - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_qs[g] <= s;
                r_qr[g] <= r;
            end
        end
    end

    // rounded dividend
    logic [38:0] r_num [3];
    logic [24:0] r_len;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len <= r_qr[6][24:0];
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= {r_dl[9].m[i], 14'd0} + 39'(r_qr[6][24:1]);
            end
        end
    end

    // restoring division, four quotient bits per stage
    logic [39:0] r_dv_rem [4][3];
    logic [15:0] r_dv_q   [4][3];
    logic [24:0] r_dv_len [4];

    for (genvar g = 0; g < 4; g++) begin : g_div
        logic [39:0] rem_in [3];
        logic [15:0] q_in   [3];
        logic [24:0] len_in;
        logic [39:0] rem    [3];
        logic [15:0] q      [3];
        logic [39:0] d;
        if (g == 0) begin : g_first
            for (genvar c = 0; c < 3; c++) begin : g_c
                assign rem_in[c] = 40'(r_num[c]);
                assign q_in[c]   = '0;
            end
            assign len_in = r_len;
        end else begin : g_next
            assign rem_in = r_dv_rem[g-1];
            assign q_in   = r_dv_q[g-1];
            assign len_in = r_dv_len[g-1];
        end
        always_comb begin
            rem = rem_in;
            q   = q_in;
            d   = '0;
            for (int j = 0; j < 4; j++) begin
                d = 40'(len_in) << (15 - (4 * g + j));
                for (int c = 0; c < 3; c++) begin
                    if (rem[c] >= d) begin
                        rem[c] = rem[c] - d;
                        q[c][15 - (4 * g + j)] = 1'b1;
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_rem[g] <= rem;
                r_dv_q[g]   <= q;
                r_dv_len[g] <= len_in;
            end
        end
    end

    // final sign
    t_s16 r_out [3];
    logic r_nz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_out[i] <= r_dl[14].sgn[i] ? -$signed(r_dv_q[3][i]) : $signed(r_dv_q[3][i]);
            end
            r_nz <= r_dl[14].nz;
        end
    end

    assign o_unit = r_out;
    assign o_nz   = r_nz;

endmodule

FILE: tb/mirrored_triangle_normal_tangent_tb.sv
module mirrored_triangle_normal_tangent_tb;
    import mtnt_pkg::*;

    // field order follows the output bus, highest bits first
    typedef struct packed {
        logic [15:0] tan_z, tan_y, tan_x;
        logic [15:0] nrm_z, nrm_y, nrm_x;
        logic [31:0] pos_z, pos_y, pos_x;
        logic        last;
    } t_vertex;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // first_x, first_y, first_z, second_x .. third_z
    logic [143:0] s_axis_tdata;
    // mirror_x, mirror_y, mirror_z
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // position_x/y/z, normal_x/y/z, tangent_x/y/z
    logic [191:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         i_cfg_wen;
    logic [1:0]   i_cfg_idx;
    logic [15:0]  i_cfg_wdata;

    logic [15:0] scale_q [3];
    t_vertex     vertex_q [$];
    int          n_errors;
    int          send_gap_pct;
    int          recv_stall_pct;

    mirrored_triangle_normal_tangent DUT (.*);

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] mag_of(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] s);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s = s - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // unit vector with 14 fraction bits; returns 0 for the zero vector
    function automatic bit unit_vector(input logic signed [63:0] v [3],
                                       output logic [15:0] u [3]);
        logic [63:0] m [3];
        logic [63:0] top, sum, len, q;
        top = 0;
        sum = 0;
        for (int a = 0; a < 3; a++) begin
            m[a] = mag_of(v[a]);
            if (m[a] > top) top = m[a];
        end
        if (top == 0) return 0;
        while (top >= (64'd1 << 24)) begin
            for (int a = 0; a < 3; a++) m[a] >>= 1;
            top >>= 1;
        end
        while (top < (64'd1 << 23)) begin
            for (int a = 0; a < 3; a++) m[a] <<= 1;
            top <<= 1;
        end
        for (int a = 0; a < 3; a++) sum += m[a] * m[a];
        len = int_sqrt(sum);
        for (int a = 0; a < 3; a++) begin
            q = ((m[a] << 14) + (len >> 1)) / len;
            u[a] = v[a] < 0 ? 16'(-q) : 16'(q);
        end
        return 1;
    endfunction

    task automatic predict_vertices(logic [143:0] coords, logic [2:0] mirror);
        logic signed [63:0] sc [3];
        logic signed [63:0] p [3][3];
        logic signed [63:0] e1 [3];
        logic signed [63:0] e2 [3];
        logic signed [63:0] r1 [3];
        logic signed [63:0] r2 [3];
        logic signed [63:0] cr [3];
        logic [15:0] nrm [3];
        logic [15:0] tng [3];
        logic [63:0] top;
        int src, shift;
        bit odd;
        t_vertex vx;
        top = 0;
        for (int a = 0; a < 3; a++) begin
            sc[a] = $signed(scale_q[a]);
            if (mirror[a]) sc[a] = (sc[a] == -32768) ? 64'sd32767 : -sc[a];
        end
        odd = ^mirror;
        for (int k = 0; k < 3; k++) begin
            src = (odd && k != 0) ? 3 - k : k;
            for (int a = 0; a < 3; a++)
                p[k][a] = sc[a] * $signed(coords[(src*3+a)*16 +: 16]);
        end
        for (int a = 0; a < 3; a++) begin
            e1[a] = p[1][a] - p[0][a];
            e2[a] = p[2][a] - p[0][a];
            if (mag_of(e1[a]) > top) top = mag_of(e1[a]);
            if (mag_of(e2[a]) > top) top = mag_of(e2[a]);
        end
        shift = 0;
        while ((top >> shift) >= (64'd1 << 30)) shift++;
        for (int a = 0; a < 3; a++) begin
            r1[a] = mag_of(e1[a]) >> shift;
            r2[a] = mag_of(e2[a]) >> shift;
            if (e1[a] < 0) r1[a] = -r1[a];
            if (e2[a] < 0) r2[a] = -r2[a];
        end
        cr[0] = r1[1] * r2[2] - r1[2] * r2[1];
        cr[1] = r1[2] * r2[0] - r1[0] * r2[2];
        cr[2] = r1[0] * r2[1] - r1[1] * r2[0];
        if (!unit_vector(cr, nrm) || !unit_vector(e1, tng)) begin
            nrm = '{16'd0, UNIT_ONE, 16'd0};
            tng = '{UNIT_ONE, 16'd0, 16'd0};
        end
        for (int k = 0; k < 3; k++) begin
            vx.pos_x = p[k][0][31:0];
            vx.pos_y = p[k][1][31:0];
            vx.pos_z = p[k][2][31:0];
            vx.nrm_x = nrm[0];
            vx.nrm_y = nrm[1];
            vx.nrm_z = nrm[2];
            vx.tan_x = tng[0];
            vx.tan_y = tng[1];
            vx.tan_z = tng[2];
            vx.last  = (k == 2);
            vertex_q.push_back(vx);
        end
    endtask

    task automatic send_triangle(logic [143:0] coords, logic [2:0] mirror);
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= coords;
        s_axis_tuser  <= mirror;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_vertices(coords, mirror);
    endtask

    task automatic write_scale(t_cfg_idx idx, logic [15:0] value);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        scale_q[idx] = value;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (vertex_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAST + 8) @(posedge i_clk);
    endtask

    task automatic set_scales(logic [15:0] sx, logic [15:0] sy, logic [15:0] sz);
        wait_drained();
        write_scale(CFG_SCALE_X, sx);
        write_scale(CFG_SCALE_Y, sy);
        write_scale(CFG_SCALE_Z, sz);
        i_cfg_wen <= 1'b0;
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(16) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [143:0] rand_triangle();
        logic [143:0] t;
        for (int i = 0; i < 9; i++) t[i*16 +: 16] = rand_coord();
        // some degenerate faces: repeated vertices
        case ($urandom_range(9))
            0: t[47:0] = t[95:48];
            1: t[143:96] = t[47:0];
            default: ;
        endcase
        return t;
    endfunction

    task automatic test_directed();
        logic [143:0] t;
        send_triangle({16'd0, 16'd0, 16'd1, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0}, 3'b000);
        for (int m = 0; m < 8; m++)
            send_triangle({16'd3, 16'd0, 16'd0, 16'd0, 16'd7, 16'hfffb, 16'd2, 16'd1, 16'd0},
                          3'(m));
        send_triangle('0, 3'b000);
        send_triangle({3{16'd5, 16'd5, 16'd5}}, 3'b101);
        // collinear vertices
        send_triangle({16'd0, 16'd0, 16'd4, 16'd0, 16'd0, 16'd2, 16'd0, 16'd0, 16'd0}, 3'b000);
        send_triangle({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                       16'h7fff, 16'h8000, 16'h7fff}, 3'b111);
        send_triangle({9{16'hffff}} ^ {16'h0, 16'h1, 16'h0, 16'h0, 16'h0, 16'h1,
                       16'h0, 16'h0, 16'h0}, 3'b010);
        t = {16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
             16'h8000, 16'h8000, 16'h7fff};
        send_triangle(t, 3'b001);
        send_triangle(~t, 3'b110);
    endtask

    task automatic test_scale_extremes();
        // most negative scale, mirrored, saturates
        set_scales(16'h8000, 16'h7fff, 16'h0001);
        for (int m = 0; m < 8; m++) send_triangle(rand_triangle(), 3'(m));
        set_scales(16'h8000, 16'h8000, 16'h8000);
        for (int m = 0; m < 8; m++) send_triangle(rand_triangle(), 3'(m));
        set_scales(16'h0000, 16'h1000, 16'hffff);
        for (int m = 0; m < 4; m++) send_triangle(rand_triangle(), 3'(m));
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0)
                set_scales(16'($urandom), 16'($urandom), 16'($urandom));
            send_triangle(rand_triangle(), 3'($urandom));
        end
    endtask

    always @(posedge i_clk) begin
        t_vertex got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata, m_axis_tlast};
                if (vertex_q.size() == 0) begin
                    $error("vertex transfer with none expected");
                    n_errors++;
                end else begin
                    want = vertex_q.pop_front();
                    if (got.pos_x !== want.pos_x) begin
                        $error("position_x exp %h got %h", want.pos_x, got.pos_x); n_errors++;
                    end
                    if (got.pos_y !== want.pos_y) begin
                        $error("position_y exp %h got %h", want.pos_y, got.pos_y); n_errors++;
                    end
                    if (got.pos_z !== want.pos_z) begin
                        $error("position_z exp %h got %h", want.pos_z, got.pos_z); n_errors++;
                    end
                    if (got.nrm_x !== want.nrm_x) begin
                        $error("normal_x exp %h got %h", want.nrm_x, got.nrm_x); n_errors++;
                    end
                    if (got.nrm_y !== want.nrm_y) begin
                        $error("normal_y exp %h got %h", want.nrm_y, got.nrm_y); n_errors++;
                    end
                    if (got.nrm_z !== want.nrm_z) begin
                        $error("normal_z exp %h got %h", want.nrm_z, got.nrm_z); n_errors++;
                    end
                    if (got.tan_x !== want.tan_x) begin
                        $error("tangent_x exp %h got %h", want.tan_x, got.tan_x); n_errors++;
                    end
                    if (got.tan_y !== want.tan_y) begin
                        $error("tangent_y exp %h got %h", want.tan_y, got.tan_y); n_errors++;
                    end
                    if (got.tan_z !== want.tan_z) begin
                        $error("tangent_z exp %h got %h", want.tan_z, got.tan_z); n_errors++;
                    end
                    if (got.last !== want.last) begin
                        $error("last_vertex exp %b got %b", want.last, got.last); n_errors++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #20_000_000;
        $display("mirrored_triangle_normal_tangent test failed");
        $finish;
    end

    initial begin
        n_errors = 0;
        send_gap_pct = 8;
        recv_stall_pct = 76;
        scale_q = '{16'd4096, 16'd4096, 16'd4096};
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        i_cfg_wen = 1'b0;
        i_cfg_idx = CFG_SCALE_X;
        i_cfg_wdata = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_scale_extremes();
        test_random(110);
        send_gap_pct = 76;
        recv_stall_pct = 8;
        test_random(110);
        send_gap_pct = 0;
        recv_stall_pct = 0;
        test_random(110);
        set_scales(16'd4096, 16'd4096, 16'd4096);
        wait_drained();
        if (n_errors == 0)
            $display("mirrored_triangle_normal_tangent test passed");
        else
            $display("mirrored_triangle_normal_tangent test failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mtnt_pkg.sv
rtl/mtnt_norm.sv
rtl/mirrored_triangle_normal_tangent.sv
tb/mirrored_triangle_normal_tangent_tb.sv
